// ===== rtl/core/mrb_pkg.sv =====
// Shared types and codes for the message ring buffer.
package mrb_pkg;

  localparam int LEN_W = 9;
  localparam int BYTE_W = 8;
  localparam int DCAP_W = 7;

  localparam logic [1:0] OP_BEGIN = 2'd0;
  localparam logic [1:0] OP_DATA = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] ST_INS_OK = 2'd0;
  localparam logic [1:0] ST_INS_REJ = 2'd1;
  localparam logic [1:0] ST_DELIVERED = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  localparam logic [LEN_W-1:0] CAP_RESET = 9'd256;

  typedef struct packed {
    logic [1:0]        op;
    logic [LEN_W-1:0]  msg_len;
    logic [BYTE_W-1:0] data_byte;
    logic [DCAP_W-1:0] dest_cap;
  } mrb_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic [LEN_W-1:0]  full_len;
    logic              last;
  } mrb_out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LEN_WAIT,
    S_ZERO,
    S_STREAM
  } mrb_state_t;

  typedef enum logic [2:0] {
    OSEL_NONE,
    OSEL_INSERT,
    OSEL_EMPTY,
    OSEL_ZERO,
    OSEL_BYTE
  } mrb_osel_t;

  typedef struct packed {
    logic      do_insert;
    logic      do_data;
    logic      lq_read;
    logic      start_rm;
    logic      issue;
    logic      s1_move;
    mrb_osel_t osel;
  } mrb_cmd_t;

  typedef struct packed {
    logic [1:0] in_op;
    logic       lq_empty;
    logic       n_zero;
    logic       icnt_zero;
    logic       s1_valid;
    logic       s1_last;
    logic       out_free;
  } mrb_stat_t;

endpackage

// ===== rtl/core/message_ring_buffer_unit.sv =====
// Insert: the result goes to the output register on accept; a data item gives no result.
// Remove: the length RAM is read, then count and pointer load, then one byte per cycle
// while the output is not stalled, paced by the registered read ports of the two RAMs.
// The next item is taken once the last result of a remove is in the output register.
// Synchronous reset clears pointers, counts and handshake state, capacity to 256;
// RAM contents are left as they are and never read before being written.
module message_ring_buffer_unit #(
  parameter int DEPTH = 256,
  parameter int MAX_DELIVER = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [mrb_pkg::LEN_W-1:0] cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  mrb_pkg::mrb_in_t          in_item,
  output logic                      out_valid,
  input  logic                      out_stall,
  output mrb_pkg::mrb_out_t         out_item
);
  import mrb_pkg::*;

  mrb_cmd_t  cmd;
  mrb_stat_t stat;

  mrb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  mrb_datapath #(.DEPTH(DEPTH), .MAX_DELIVER(MAX_DELIVER)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_item     (in_item),
    .out_stall   (out_stall),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_item    (out_item)
  );

endmodule

// ===== rtl/core/mrb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/mrb_ctrl.sv =====
// Controller state machine: sequences insert, data and remove items.
module mrb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  mrb_pkg::mrb_stat_t stat,
  output mrb_pkg::mrb_cmd_t  cmd
);
  import mrb_pkg::*;

  mrb_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.osel = OSEL_NONE;
    in_stall = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = !stat.out_free;
        if (in_valid && stat.out_free) begin
          case (stat.in_op)
            OP_BEGIN: begin
              cmd.do_insert = 1'b1;
              cmd.osel = OSEL_INSERT;
            end
            OP_DATA: begin
              cmd.do_data = 1'b1;
            end
            OP_REMOVE: begin
              if (stat.lq_empty) begin
                cmd.osel = OSEL_EMPTY;
              end else begin
                cmd.lq_read = 1'b1;
                state_next = S_LEN_WAIT;
              end
            end
            default: ;
          endcase
        end
      end
      S_LEN_WAIT: begin
        cmd.start_rm = 1'b1;
        state_next = stat.n_zero ? S_ZERO : S_STREAM;
      end
      S_ZERO: begin
        if (stat.out_free) begin
          cmd.osel = OSEL_ZERO;
          state_next = S_IDLE;
        end
      end
      S_STREAM: begin
        cmd.s1_move = stat.s1_valid && stat.out_free;
        cmd.issue = !stat.icnt_zero && (!stat.s1_valid || cmd.s1_move);
        if (cmd.s1_move) begin
          cmd.osel = OSEL_BYTE;
          if (stat.s1_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/mrb_datapath.sv =====
// Datapath: pointers, counters, ring and length memories, output register.
module mrb_datapath #(
  parameter int DEPTH = 256,
  parameter int MAX_DELIVER = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [mrb_pkg::LEN_W-1:0]   cfg_wr_data,
  input  mrb_pkg::mrb_in_t            in_item,
  input  logic                        out_stall,
  input  mrb_pkg::mrb_cmd_t           cmd,
  output mrb_pkg::mrb_stat_t          stat,
  output logic                        out_valid,
  output mrb_pkg::mrb_out_t           out_item
);
  import mrb_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int LCW = $clog2(DEPTH + 1);
  localparam logic [LEN_W-1:0] DEPTH_LIM = (DEPTH > 511) ? 9'd511 : LEN_W'(DEPTH);
  localparam logic [LCW-1:0] LQ_FULL = LCW'(DEPTH);
  localparam logic [AW-1:0] LQ_LAST = AW'(DEPTH - 1);
  localparam logic [DCAP_W-1:0] DMAX = DCAP_W'(MAX_DELIVER);

  logic [LEN_W-1:0]  capacity, eff_cap;
  logic [LEN_W-1:0]  write_ptr, write_ptr_next;
  logic [LEN_W-1:0]  read_ptr, read_ptr_next;
  logic [LEN_W-1:0]  sptr, sptr_next;
  logic [LEN_W-1:0]  occupancy, occupancy_next;
  logic [LEN_W-1:0]  bytes_pending, bytes_pending_next;
  logic [AW-1:0]     len_head, len_head_next;
  logic [AW-1:0]     len_tail, len_tail_next;
  logic [LCW-1:0]    len_count, len_count_next;
  logic [DCAP_W-1:0] rm_dcap;
  logic [LEN_W-1:0]  full_len_q;
  logic [DCAP_W-1:0] icnt, icnt_next;
  logic              s1_valid, s1_last;

  logic [LEN_W-1:0]  room, lq_rdata, n_full;
  logic [BYTE_W-1:0] ring_rdata;
  logic [LEN_W:0]    rp_sum;
  logic              ins_ok, data_wr, out_free;

  assign eff_cap = (capacity == '0) ? LEN_W'(1) :
                   (capacity > DEPTH_LIM) ? DEPTH_LIM : capacity;
  assign room = (occupancy < eff_cap) ? eff_cap - occupancy : '0;
  assign ins_ok = (bytes_pending == '0) && (len_count != LQ_FULL) &&
                  (in_item.msg_len <= room);
  assign data_wr = cmd.do_data && (bytes_pending != '0);
  assign out_free = !out_valid || !out_stall;

  // delivered count: stored length clipped to the reader's capacity
  assign n_full = (lq_rdata < {2'b00, rm_dcap}) ? lq_rdata : {2'b00, rm_dcap};
  assign rp_sum = {1'b0, read_ptr} + {1'b0, lq_rdata};

  mrb_ram #(.WIDTH(BYTE_W), .DEPTH(DEPTH)) u_ring (
    .clk   (clk),
    .we    (data_wr),
    .waddr (AW'(write_ptr)),
    .wdata (in_item.data_byte),
    .re    (cmd.issue),
    .raddr (AW'(sptr)),
    .rdata (ring_rdata)
  );

  mrb_ram #(.WIDTH(LEN_W), .DEPTH(DEPTH)) u_lenq (
    .clk   (clk),
    .we    (cmd.do_insert && ins_ok),
    .waddr (len_tail),
    .wdata (in_item.msg_len),
    .re    (cmd.lq_read),
    .raddr (len_head),
    .rdata (lq_rdata)
  );

  always_comb begin
    write_ptr_next = write_ptr;
    read_ptr_next = read_ptr;
    sptr_next = sptr;
    occupancy_next = occupancy;
    bytes_pending_next = bytes_pending;
    len_head_next = len_head;
    len_tail_next = len_tail;
    len_count_next = len_count;
    icnt_next = icnt;

    if (cmd.do_insert && ins_ok) begin
      occupancy_next = occupancy + in_item.msg_len;
      bytes_pending_next = in_item.msg_len;
      if (in_item.msg_len == '0) begin
        len_tail_next = (len_tail == LQ_LAST) ? '0 : len_tail + 1'b1;
        len_count_next = len_count + 1'b1;
      end
    end

    if (data_wr) begin
      write_ptr_next = (write_ptr + 1'b1 == eff_cap) ? '0 : write_ptr + 1'b1;
      bytes_pending_next = bytes_pending - 1'b1;
      if (bytes_pending == LEN_W'(1)) begin
        len_tail_next = (len_tail == LQ_LAST) ? '0 : len_tail + 1'b1;
        len_count_next = len_count + 1'b1;
      end
    end

    if (cmd.start_rm) begin
      sptr_next = read_ptr;
      icnt_next = n_full[DCAP_W-1:0];
      read_ptr_next = (rp_sum >= {1'b0, eff_cap}) ? LEN_W'(rp_sum - {1'b0, eff_cap}) :
                      rp_sum[LEN_W-1:0];
      occupancy_next = (occupancy >= lq_rdata) ? occupancy - lq_rdata : '0;
      len_head_next = (len_head == LQ_LAST) ? '0 : len_head + 1'b1;
      len_count_next = len_count - 1'b1;
    end

    if (cmd.issue) begin
      sptr_next = (sptr + 1'b1 == eff_cap) ? '0 : sptr + 1'b1;
      icnt_next = icnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr_en) begin
      write_ptr <= '0;
      read_ptr <= '0;
      sptr <= '0;
      occupancy <= '0;
      bytes_pending <= '0;
      len_head <= '0;
      len_tail <= '0;
      len_count <= '0;
      icnt <= '0;
    end else begin
      write_ptr <= write_ptr_next;
      read_ptr <= read_ptr_next;
      sptr <= sptr_next;
      occupancy <= occupancy_next;
      bytes_pending <= bytes_pending_next;
      len_head <= len_head_next;
      len_tail <= len_tail_next;
      len_count <= len_count_next;
      icnt <= icnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.issue) begin
        s1_valid <= 1'b1;
      end else if (cmd.s1_move) begin
        s1_valid <= 1'b0;
      end
      if (cmd.osel != OSEL_NONE) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lq_read) begin
      rm_dcap <= (in_item.dest_cap > DMAX) ? DMAX : in_item.dest_cap;
    end
    if (cmd.start_rm) begin
      full_len_q <= lq_rdata;
    end
    if (cmd.issue) begin
      s1_last <= (icnt == DCAP_W'(1));
    end
    case (cmd.osel)
      OSEL_INSERT: out_item <= '{status: ins_ok ? ST_INS_OK : ST_INS_REJ, out_byte: '0,
                                 byte_valid: 1'b0, full_len: '0, last: 1'b1};
      OSEL_EMPTY:  out_item <= '{status: ST_EMPTY, out_byte: '0, byte_valid: 1'b0,
                                 full_len: '0, last: 1'b1};
      OSEL_ZERO:   out_item <= '{status: ST_DELIVERED, out_byte: '0, byte_valid: 1'b0,
                                 full_len: full_len_q, last: 1'b1};
      OSEL_BYTE:   out_item <= '{status: ST_DELIVERED, out_byte: ring_rdata,
                                 byte_valid: 1'b1, full_len: full_len_q, last: s1_last};
      default: ;
    endcase
  end

  always_comb begin
    stat.in_op = in_item.op;
    stat.lq_empty = (len_count == '0);
    stat.n_zero = (n_full == '0);
    stat.icnt_zero = (icnt == '0);
    stat.s1_valid = s1_valid;
    stat.s1_last = s1_last;
    stat.out_free = out_free;
  end

endmodule

// ===== rtl/core/mrb_checker.sv =====
// Port-level checks for the message ring buffer, bound to the top level.
module mrb_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input mrb_pkg::mrb_in_t          in_item,
  input logic                      out_valid,
  input logic                      out_stall,
  input mrb_pkg::mrb_out_t         out_item
);
  import mrb_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled output item changed");

  a_insert_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_item.op == OP_BEGIN |=>
      out_valid && out_item.last && !out_item.byte_valid &&
      (out_item.status == ST_INS_OK || out_item.status == ST_INS_REJ))
    else $error("begin item without its insert result");

  a_byte_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.byte_valid |-> out_item.status == ST_DELIVERED &&
      out_item.full_len != '0)
    else $error("message byte on a non-delivery result");

  a_empty_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status == ST_EMPTY |->
      out_item.last && !out_item.byte_valid && out_item.full_len == '0)
    else $error("malformed empty result");

endmodule

bind message_ring_buffer_unit mrb_checker u_mrb_checker (.*);
